// ===== rtl/spma_pkg.sv =====
// ----------------------------------------------------------------------------
// spma_pkg
// Shared types, codes and helpers for the symbolic permission mode applier.
// ----------------------------------------------------------------------------
`default_nettype none

package spma_pkg;

   localparam int MODE_W   = 12;
   localparam int RWX_W    = 9;
   localparam int SPEC_W   = 3;
   localparam int SYM_W    = 8;

   localparam logic [RWX_W-1:0] UMASK_RESET = 9'o022;
   localparam logic [RWX_W-1:0] RWX_ALL     = 9'o777;

   typedef enum logic [1:0] {
      CMD_BEGIN = 2'd0,
      CMD_CHAR  = 2'd1,
      CMD_END   = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_ADD  = 2'd1,
      OP_SUB  = 2'd2,
      OP_SET  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      PHASE_CLAUSE = 3'b001,
      PHASE_WHO    = 3'b010,
      PHASE_PERM   = 3'b100
   } phase_type;

   // ASCII codes of the mode text
   localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [SYM_W-1:0] CH_EQUAL = 8'h3D;
   localparam logic [SYM_W-1:0] CH_COMMA = 8'h2C;
   localparam logic [SYM_W-1:0] CH_U     = 8'h75;
   localparam logic [SYM_W-1:0] CH_G     = 8'h67;
   localparam logic [SYM_W-1:0] CH_O     = 8'h6F;
   localparam logic [SYM_W-1:0] CH_A     = 8'h61;
   localparam logic [SYM_W-1:0] CH_R     = 8'h72;
   localparam logic [SYM_W-1:0] CH_W     = 8'h77;
   localparam logic [SYM_W-1:0] CH_X     = 8'h78;
   localparam logic [SYM_W-1:0] CH_BIG_X = 8'h58;
   localparam logic [SYM_W-1:0] CH_S     = 8'h73;
   localparam logic [SYM_W-1:0] CH_T     = 8'h74;

   // pending operator context handed to the apply logic
   typedef struct packed {
      logic [2:0]        who_set;
      logic              who_given;
      op_type            op;
      logic [RWX_W-1:0]  rwx;
      logic [SPEC_W-1:0] special;   // [2] setuid, [1] setgid, [0] sticky
   } op_state_type;

   typedef struct packed {
      logic [MODE_W-1:0] result_mode;
      logic              valid_res;
   } result_type;

   // who bit0 u, bit1 g, bit2 o
   function automatic logic [RWX_W-1:0] spread(input logic [2:0] who,
                                                input logic [2:0] triple);
      spread = {triple & {3{who[0]}}, triple & {3{who[1]}}, triple & {3{who[2]}}};
   endfunction

endpackage

`default_nettype wire

// ===== rtl/spma_apply.sv =====
// ----------------------------------------------------------------------------
// spma_apply
// Applies one pending operator to a mode word.
// ----------------------------------------------------------------------------
`default_nettype none

module spma_apply
   import spma_pkg::*;
(
   input  wire logic [MODE_W-1:0] mode_i,
   input  wire logic [RWX_W-1:0]  umask_i,
   input  wire op_state_type      op_i,
   output logic      [MODE_W-1:0] mode_o
);

   logic [2:0]        who;
   logic [RWX_W-1:0]  affected;
   logic [RWX_W-1:0]  clear_rwx;
   logic [SPEC_W-1:0] special_mask;
   logic [RWX_W-1:0]  applied;
   logic [MODE_W-1:0] set_bits;

   always_comb begin
      who      = op_i.who_given ? op_i.who_set : 3'b111;
      affected = spread(who, 3'b111);
      if (!op_i.who_given) begin
         affected = affected & ~umask_i;
      end
      clear_rwx    = (op_i.op == OP_SET && !op_i.who_given) ? RWX_ALL : affected;
      special_mask = op_i.who_given ? {who[0], who[1], who[2]} : 3'b111;
      applied      = op_i.rwx & affected;
      set_bits     = {op_i.special, applied};
      unique case (op_i.op)
         OP_ADD:  mode_o = mode_i | set_bits;
         OP_SUB:  mode_o = mode_i & ~set_bits;
         OP_SET:  mode_o = (mode_i & ~{special_mask, clear_rwx}) | set_bits;
         default: mode_o = mode_i;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/spma_parser.sv =====
// ----------------------------------------------------------------------------
// spma_parser
// Parse state, umask register and per-request next-state logic.
// ----------------------------------------------------------------------------
`default_nettype none

module spma_parser
   import spma_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept_i,
   input  wire logic [1:0]        cmd_i,
   input  wire logic [MODE_W-1:0] start_mode_i,
   input  wire logic              is_directory_i,
   input  wire logic [SYM_W-1:0]  symbol_i,
   input  wire logic              csr_wr_en,
   input  wire logic [RWX_W-1:0]  csr_wr_data,
   output logic                   res_push_o,
   output result_type             res_o
);

   logic [RWX_W-1:0]  umask_ff;
   logic [MODE_W-1:0] work_mode_ff, work_mode_in;
   logic [MODE_W-1:0] mbo_ff, mbo_in;
   op_state_type      op_ff, op_in;
   phase_type         phase_ff, phase_in;
   logic              dir_ff, dir_in;
   logic              err_ff, err_in;
   logic              empty_ff, empty_in;

   logic [MODE_W-1:0] applied_mode;
   op_type            sym_op;
   logic [2:0]        who;
   logic              ok;

   spma_apply u_apply (
      .mode_i  (work_mode_ff),
      .umask_i (umask_ff),
      .op_i    (op_ff),
      .mode_o  (applied_mode)
   );

   always_comb begin
      priority if (symbol_i == CH_PLUS)  sym_op = OP_ADD;
      else if     (symbol_i == CH_MINUS) sym_op = OP_SUB;
      else if     (symbol_i == CH_EQUAL) sym_op = OP_SET;
      else                               sym_op = OP_NONE;
   end

   always_comb begin
      work_mode_in = work_mode_ff;
      mbo_in       = mbo_ff;
      op_in        = op_ff;
      phase_in     = phase_ff;
      dir_in       = dir_ff;
      err_in       = err_ff;
      empty_in     = empty_ff;
      who          = op_ff.who_given ? op_ff.who_set : 3'b111;

      if (accept_i) begin
         unique case (cmd_i)
            CMD_BEGIN: begin
               work_mode_in = start_mode_i;
               dir_in       = is_directory_i;
               mbo_in       = '0;
               op_in        = '{3'b000, 1'b0, OP_NONE, '0, '0};
               phase_in     = PHASE_CLAUSE;
               err_in       = 1'b0;
               empty_in     = 1'b1;
            end
            CMD_CHAR: begin
               if (!err_ff) begin
                  empty_in = 1'b0;
                  if (phase_ff != PHASE_PERM) begin
                     priority if (symbol_i == CH_U || symbol_i == CH_G ||
                                  symbol_i == CH_O || symbol_i == CH_A) begin
                        op_in.who_given = 1'b1;
                        phase_in        = PHASE_WHO;
                        priority if (symbol_i == CH_U) op_in.who_set[0] = 1'b1;
                        else if     (symbol_i == CH_G) op_in.who_set[1] = 1'b1;
                        else if     (symbol_i == CH_O) op_in.who_set[2] = 1'b1;
                        else                           op_in.who_set    = 3'b111;
                     end else if (sym_op != OP_NONE) begin
                        op_in.op      = sym_op;
                        op_in.rwx     = '0;
                        op_in.special = '0;
                        mbo_in        = work_mode_ff;
                        phase_in      = PHASE_PERM;
                     end else begin
                        err_in = 1'b1;
                     end
                  end else if (sym_op != OP_NONE) begin
                     // close the running operator, start the next one
                     work_mode_in  = applied_mode;
                     mbo_in        = applied_mode;
                     op_in.op      = sym_op;
                     op_in.rwx     = '0;
                     op_in.special = '0;
                  end else if (symbol_i == CH_COMMA) begin
                     work_mode_in = applied_mode;
                     op_in        = '{3'b000, 1'b0, OP_NONE, '0, '0};
                     phase_in     = PHASE_CLAUSE;
                  end else begin
                     priority if (symbol_i == CH_R)
                        op_in.rwx = op_ff.rwx | spread(who, 3'b100);
                     else if (symbol_i == CH_W)
                        op_in.rwx = op_ff.rwx | spread(who, 3'b010);
                     else if (symbol_i == CH_X)
                        op_in.rwx = op_ff.rwx | spread(who, 3'b001);
                     else if (symbol_i == CH_BIG_X) begin
                        if (dir_ff || mbo_ff[6] || mbo_ff[3] || mbo_ff[0]) begin
                           op_in.rwx = op_ff.rwx | spread(who, 3'b001);
                        end
                     end else if (symbol_i == CH_S)
                        op_in.special = op_ff.special | {who[0], who[1], 1'b0};
                     else if (symbol_i == CH_T)
                        op_in.special = op_ff.special | {2'b00, who[2]};
                     else if (symbol_i == CH_U)
                        op_in.rwx = op_ff.rwx | spread(who, mbo_ff[8:6]);
                     else if (symbol_i == CH_G)
                        op_in.rwx = op_ff.rwx | spread(who, mbo_ff[5:3]);
                     else if (symbol_i == CH_O)
                        op_in.rwx = op_ff.rwx | spread(who, mbo_ff[2:0]);
                     else
                        err_in = 1'b1;
                  end
               end
            end
            default: begin
               // end leaves the state alone; unused code is ignored
            end
         endcase
      end
   end

   assign ok                = !err_ff && !empty_ff && (phase_ff == PHASE_PERM);
   assign res_push_o        = accept_i && (cmd_i == CMD_END);
   assign res_o.result_mode = ok ? applied_mode : '0;
   assign res_o.valid_res   = ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         umask_ff     <= UMASK_RESET;
         work_mode_ff <= '0;
         mbo_ff       <= '0;
         op_ff        <= '{3'b000, 1'b0, OP_NONE, '0, '0};
         phase_ff     <= PHASE_CLAUSE;
         dir_ff       <= 1'b0;
         err_ff       <= 1'b0;
         empty_ff     <= 1'b1;
      end else begin
         if (csr_wr_en) begin
            umask_ff <= csr_wr_data;
         end
         work_mode_ff <= work_mode_in;
         mbo_ff       <= mbo_in;
         op_ff        <= op_in;
         phase_ff     <= phase_in;
         dir_ff       <= dir_in;
         err_ff       <= err_in;
         empty_ff     <= empty_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/spma_out_buf.sv =====
// ----------------------------------------------------------------------------
// spma_out_buf
// Result register with a one-entry skid stage.
// ----------------------------------------------------------------------------
`default_nettype none

module spma_out_buf
   import spma_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push_i,
   input  wire result_type data_i,
   output logic            full_o,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output result_type      data_o
);

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       pop;

   assign pop = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      priority if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push_i) begin
         if (!out_valid_ff || pop) begin
            out_data_in  = data_i;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = data_i;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full_o    = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign data_o    = out_data_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without a result in the output register");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push_i |-> !skid_valid_ff)
      else $error("result pushed while skid stage full");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_stall) |=> (out_valid_ff && !skid_valid_ff))
      else $error("skid entry not moved to output after pop");

endmodule

`default_nettype wire

// ===== rtl/symbolic_permission_mode_apply.sv =====
// ----------------------------------------------------------------------------
// symbolic_permission_mode_apply
// Applies a streamed symbolic mode text (u+x,go-w style) to a 12-bit mode.
// ----------------------------------------------------------------------------
// An end request's result is registered, into the skid entry during a stall.
// Throughput: one request per cycle while req_stall is low; the parse state
// updates in a single pass, and the skid stage keeps requests flowing while
// a result is stalled. Requests stall only when result register and skid are full.
// Reset (synchronous): parse state cleared, work mode zero, umask 0o022.
`default_nettype none

module symbolic_permission_mode_apply
   import spma_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [1:0]        req_cmd,
   input  wire logic [MODE_W-1:0] req_start_mode,
   input  wire logic              req_is_directory,
   input  wire logic [SYM_W-1:0]  req_symbol,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic      [MODE_W-1:0] rsp_result_mode,
   output logic                   rsp_valid_res,
   input  wire logic              csr_wr_en,
   input  wire logic [RWX_W-1:0]  csr_wr_data
);

   logic       accept;
   logic       res_push;
   result_type res;
   result_type res_out;
   logic       full;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   spma_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .accept_i       (accept),
      .cmd_i          (req_cmd),
      .start_mode_i   (req_start_mode),
      .is_directory_i (req_is_directory),
      .symbol_i       (req_symbol),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .res_push_o     (res_push),
      .res_o          (res)
   );

   spma_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push_i    (res_push),
      .data_i    (res),
      .full_o    (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .data_o    (res_out)
   );

   assign rsp_result_mode = res_out.result_mode;
   assign rsp_valid_res   = res_out.valid_res;

endmodule

`default_nettype wire
